// File: hdl/assert_macros.svh
// Assertion macros used by the checker file.
// Each use expands to one labeled concurrent assertion that reports through $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define TWNM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define TWNM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: hdl/twnm_pkg.sv
// Shared types and constants for the tolerance window nearest match block.
// No dependencies; the design and checker modules import it.
package twnm_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int RT_W   = 24;
  localparam int MZ_W   = 32;
  localparam int PROD_W = RT_W + MZ_W;
  localparam int HALF_W = PROD_W / 2;
  localparam int SQ_W   = 2 * PROD_W;
  localparam int N_W    = SQ_W + 1;

  localparam int OP_W   = 2;
  localparam int PIDX_W = 10;
  localparam int WCNT_W = 11;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 24;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_RT_TOL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MZ_TOL = 2'd1;

  typedef struct packed {
    logic [MZ_W-1:0] mz;
    logic [RT_W-1:0] rt;
  } point_t;

  // Travels alongside each scan slot down the distance pipeline.
  typedef struct packed {
    logic             vld;
    logic             tok;   // bound slot, carries the squared tolerance product
    logic             last;
    logic [IDX_W-1:0] idx;
  } scan_tag_t;

endpackage

// File: hdl/twnm_mem.sv
// Reference point table: one write port, one read port, registered read data.
// Depends on twnm_pkg.
module twnm_mem
  import twnm_pkg::*;
(
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  point_t           wr_data,
  input  logic [IDX_W-1:0] rd_addr,
  output point_t           rd_data
);

  point_t mem [TABLE_DEPTH];
  point_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: hdl/twnm_dist.sv
// Distance pipeline: window test and squared normalized distance, five stages.
// Depends on twnm_pkg.
module twnm_dist
  import twnm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  scan_tag_t        tag_in,
  input  point_t           pt,
  input  logic [RT_W-1:0]  q_rt,
  input  logic [MZ_W-1:0]  q_mz,
  input  logic [RT_W-1:0]  rt_tol,
  input  logic [MZ_W-1:0]  mz_tol,
  output scan_tag_t        tag_out,
  output logic             inwin_out,
  output logic [N_W-1:0]   n_out
);

  logic [RT_W-1:0] rs, drt, a_nxt;
  logic [MZ_W-1:0] ms, dmz, b_nxt;

  scan_tag_t tag1_r, tag2_r, tag3_r, tag4_r, tag5_r;
  logic      win1_r, win2_r, win3_r, win4_r, win5_r;
  logic [RT_W-1:0]   a_r;
  logic [MZ_W-1:0]   b_r;
  logic [PROD_W-1:0] x_r, y_r;
  logic [PROD_W-1:0] xhh_r, xhl_r, xll_r, yhh_r, yhl_r, yll_r;
  logic [SQ_W-1:0]   x2_r, y2_r;
  logic [N_W-1:0]    n_r;

  assign rs  = (rt_tol == '0) ? RT_W'(1) : rt_tol;
  assign ms  = (mz_tol == '0) ? MZ_W'(1) : mz_tol;
  assign drt = (q_rt >= pt.rt) ? q_rt - pt.rt : pt.rt - q_rt;
  assign dmz = (q_mz >= pt.mz) ? q_mz - pt.mz : pt.mz - q_mz;

  // The bound slot feeds rs through the rt lane so it comes out as (rs*ms)^2.
  always_comb begin
    if (tag_in.tok) begin
      a_nxt = rs;
      b_nxt = '0;
    end else begin
      a_nxt = (rt_tol != '0) ? drt : '0;
      b_nxt = (mz_tol != '0) ? dmz : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
      tag3_r <= '0;
      tag4_r <= '0;
      tag5_r <= '0;
    end else begin
      tag1_r <= tag_in;
      tag2_r <= tag1_r;
      tag3_r <= tag2_r;
      tag4_r <= tag3_r;
      tag5_r <= tag4_r;
    end
  end

  always_ff @(posedge clk) begin
    // stage 1: deviations and window test
    win1_r <= (drt <= rt_tol) && (dmz <= mz_tol);
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    // stage 2: scale each deviation by the other axis tolerance
    win2_r <= win1_r;
    x_r    <= PROD_W'(a_r) * PROD_W'(ms);
    y_r    <= PROD_W'(b_r) * PROD_W'(rs);
    // stage 3: partial products of the squares
    win3_r <= win2_r;
    xhh_r  <= PROD_W'(x_r[PROD_W-1:HALF_W]) * PROD_W'(x_r[PROD_W-1:HALF_W]);
    xhl_r  <= PROD_W'(x_r[PROD_W-1:HALF_W]) * PROD_W'(x_r[HALF_W-1:0]);
    xll_r  <= PROD_W'(x_r[HALF_W-1:0]) * PROD_W'(x_r[HALF_W-1:0]);
    yhh_r  <= PROD_W'(y_r[PROD_W-1:HALF_W]) * PROD_W'(y_r[PROD_W-1:HALF_W]);
    yhl_r  <= PROD_W'(y_r[PROD_W-1:HALF_W]) * PROD_W'(y_r[HALF_W-1:0]);
    yll_r  <= PROD_W'(y_r[HALF_W-1:0]) * PROD_W'(y_r[HALF_W-1:0]);
    // stage 4: assemble the squares
    win4_r <= win3_r;
    x2_r   <= {xhh_r, {(2*HALF_W){1'b0}}} + SQ_W'({xhl_r, {(HALF_W+1){1'b0}}})
              + SQ_W'(xll_r);
    y2_r   <= {yhh_r, {(2*HALF_W){1'b0}}} + SQ_W'({yhl_r, {(HALF_W+1){1'b0}}})
              + SQ_W'(yll_r);
    // stage 5: sum of both axes
    win5_r <= win4_r;
    n_r    <= N_W'(x2_r) + N_W'(y2_r);
  end

  assign tag_out   = tag5_r;
  assign inwin_out = win5_r;
  assign n_out     = n_r;

endmodule

// File: hdl/tolerance_window_nearest_match.sv
// Tolerance window nearest match, top level: control, best-match update, output register.
// A query with P stored points sends the bound slot and then one table read per cycle
// through the registered table read and the distance pipeline to its result; the next
// beat is taken once the result is registered, later still while a result stalls.
// Reset clears the point count, both tolerances and the output valid; table contents are not
// cleared. Uses twnm_pkg, twnm_mem, twnm_dist.
module tolerance_window_nearest_match
  import twnm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // rt_value[23:0], mz_value[55:24]
  input  logic [OP_W-1:0]        in_tuser,   // opcode[1:0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // found[0], point_index[10:1],
                                             // window_count[21:11], zero[23:22]
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [RT_W-1:0]  rt_tol_r;
  logic [MZ_W-1:0]  mz_tol_r;
  logic [CNT_W-1:0] pt_count_r;
  logic [IDX_W-1:0] addr_r;
  logic             tok_r;
  logic [RT_W-1:0]  q_rt_r;
  logic [MZ_W-1:0]  q_mz_r;
  scan_tag_t        tag0_r, tag0_nxt, tag_s5;
  logic             inwin_s5;
  logic [N_W-1:0]   n_s5;
  logic [N_W-1:0]   best_r;
  logic [CNT_W-1:0] acc_cnt_r;
  logic [IDX_W-1:0] win_r, single_r;
  logic             have_r;
  logic             out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic             in_acc, load_en, last_addr, found;
  logic [IDX_W-1:0] res_idx;
  point_t           wr_pt, rd_pt;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign load_en   = in_acc && (in_tuser == OP_LOAD) && (pt_count_r < CNT_W'(TABLE_DEPTH));
  assign wr_pt.rt  = in_tdata[RT_W-1:0];
  assign wr_pt.mz  = in_tdata[RT_W+MZ_W-1:RT_W];
  assign last_addr = ({1'b0, addr_r} + CNT_W'(1)) == pt_count_r;

  twnm_mem u_mem (
    .clk     (clk),
    .wr_en   (load_en),
    .wr_addr (pt_count_r[IDX_W-1:0]),
    .wr_data (wr_pt),
    .rd_addr (addr_r),
    .rd_data (rd_pt)
  );

  twnm_dist u_dist (
    .clk       (clk),
    .rst_n     (rst_n),
    .tag_in    (tag0_r),
    .pt        (rd_pt),
    .q_rt      (q_rt_r),
    .q_mz      (q_mz_r),
    .rt_tol    (rt_tol_r),
    .mz_tol    (mz_tol_r),
    .tag_out   (tag_s5),
    .inwin_out (inwin_s5),
    .n_out     (n_s5)
  );

  always_comb begin
    state_nxt = state_r;
    tag0_nxt  = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_tuser == OP_QUERY)) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        tag0_nxt.vld = 1'b1;
        tag0_nxt.idx = addr_r;
        if (tok_r) begin
          tag0_nxt.tok  = 1'b1;
          tag0_nxt.last = (pt_count_r == '0);
        end else begin
          tag0_nxt.last = last_addr;
        end
        if (tag0_nxt.last) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (tag_s5.vld && tag_s5.last) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      rt_tol_r   <= '0;
      mz_tol_r   <= '0;
      pt_count_r <= '0;
      tag0_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      tag0_r     <= tag0_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_RT_TOL) begin
          rt_tol_r <= cfg_data[RT_W-1:0];
        end else if (cfg_index == REG_MZ_TOL) begin
          mz_tol_r <= cfg_data[MZ_W-1:0];
        end
      end
      if (in_acc && (in_tuser == OP_CLEAR)) begin
        pt_count_r <= '0;
      end else if (load_en) begin
        pt_count_r <= pt_count_r + CNT_W'(1);
      end
      if (state_r == ST_OUT && state_nxt == ST_IDLE) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Scan address, query latch, running best and result data.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      q_rt_r <= in_tdata[RT_W-1:0];
      q_mz_r <= in_tdata[RT_W+MZ_W-1:RT_W];
      addr_r <= '0;
      tok_r  <= 1'b1;
    end else if (state_r == ST_SCAN) begin
      if (tok_r) begin
        tok_r <= 1'b0;
      end else begin
        addr_r <= addr_r + IDX_W'(1);
      end
    end
    if (tag_s5.vld) begin
      if (tag_s5.tok) begin
        best_r    <= n_s5;
        acc_cnt_r <= '0;
        have_r    <= 1'b0;
        win_r     <= '0;
        single_r  <= '0;
      end else if (inwin_s5) begin
        if (acc_cnt_r == '0) begin
          single_r <= tag_s5.idx;
        end
        acc_cnt_r <= acc_cnt_r + CNT_W'(1);
        if (n_s5 < best_r) begin
          best_r <= n_s5;
          win_r  <= tag_s5.idx;
          have_r <= 1'b1;
        end
      end
    end
    if (state_r == ST_OUT && state_nxt == ST_IDLE) begin
      out_data_r <= {{(OUT_TDATA_W-1-PIDX_W-WCNT_W){1'b0}}, WCNT_W'(acc_cnt_r),
                     (found ? PIDX_W'(res_idx) : PIDX_W'(0)), found};
    end
  end

  assign res_idx    = (acc_cnt_r == CNT_W'(1)) ? single_r : win_r;
  assign found      = (acc_cnt_r != '0) && (have_r || (acc_cnt_r == CNT_W'(1)));
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// File: hdl/twnm_checker.sv
// Port-level checks on the result channel of the nearest match block, bound to the top.
// Depends on twnm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module twnm_checker
  import twnm_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  `TWNM_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid, "result beat dropped")
  `TWNM_ASSERT(a_out_stable, out_tvalid && !out_tready |=> $stable(out_tdata), "stalled beat changed")
  `TWNM_ASSERT(a_idx_zero, out_tvalid && !out_tdata[0] |-> out_tdata[PIDX_W:1] == '0, "index without match")
  `TWNM_ASSERT(a_found_cnt, out_tvalid && out_tdata[0] |-> out_tdata[PIDX_W+WCNT_W:PIDX_W+1] != '0, "match with empty window")
  `TWNM_ASSERT_ALWAYS(a_rst_quiet, !rst_n |=> !out_tvalid, "result after reset")

endmodule

bind tolerance_window_nearest_match twnm_checker u_twnm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
